>>> hw/rtl/tcs_pkg.sv
// Shared constants, types and helpers for the character statistics block.
package tcs_pkg;

  localparam int unsigned NumLetters = 26;
  localparam int unsigned LetterIdxW = 5;
  localparam int unsigned FieldW     = 32;
  localparam int unsigned SumW       = 31;
  localparam int unsigned NumClasses = 7;

  // class counter slots
  localparam int unsigned CcTotal  = 0;
  localparam int unsigned CcLetter = 1;
  localparam int unsigned CcUpper  = 2;
  localparam int unsigned CcLower  = 3;
  localparam int unsigned CcBlank  = 4;
  localparam int unsigned CcDigit  = 5;
  localparam int unsigned CcOther  = 6;

  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7A;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;

  localparam logic [LetterIdxW-1:0] LastLetter = LetterIdxW'(NumLetters - 1);
  localparam logic [SumW-1:0]       SumMax     = '1;

  typedef struct packed {
    logic [FieldW-1:0] total_chars;
    logic [FieldW-1:0] letter_total;
    logic [FieldW-1:0] ucase_total;
    logic [FieldW-1:0] lcase_total;
    logic [FieldW-1:0] blank_total;
    logic [FieldW-1:0] digit_total;
    logic [FieldW-1:0] other_total;
    logic [FieldW-1:0] number_count;
    logic [SumW-1:0]   number_sum;
  } tcs_totals_t;

  typedef struct packed {
    logic                  rd_en;
    logic [LetterIdxW-1:0] rd_addr;
  } tcs_rd_req_t;

  typedef struct packed {
    logic active;
    logic done;
  } tcs_rpt_ctrl_t;

  function automatic logic is_lower(input logic [7:0] b);
    is_lower = (b >= ChLowA) && (b <= ChLowZ);
  endfunction

  function automatic logic is_upper(input logic [7:0] b);
    is_upper = (b >= ChUpA) && (b <= ChUpZ);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= ChZero) && (b <= ChNine);
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    is_blank = (b == ChSpace) || (b == ChTab);
  endfunction

endpackage

>>> hw/rtl/tcs_if.sv
// Valid/ready channel interfaces for the input byte stream and the report records.
interface tcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;
  logic       last;

  modport source (output valid, output byte_req, output last, input ready);
  modport sink (input valid, input byte_req, input last, output ready);
endinterface

interface tcs_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  letter_index;
  logic [31:0] letter_count;
  logic [31:0] total_chars;
  logic [31:0] letter_total;
  logic [31:0] ucase_total;
  logic [31:0] lcase_total;
  logic [31:0] blank_total;
  logic [31:0] digit_total;
  logic [31:0] other_total;
  logic [31:0] number_count;
  logic [30:0] number_sum;
  logic        last_record;

  modport source (output valid, output letter_index, output letter_count, output total_chars,
                  output letter_total, output ucase_total, output lcase_total,
                  output blank_total, output digit_total, output other_total,
                  output number_count, output number_sum, output last_record,
                  input ready);
  modport sink (input valid, input letter_index, input letter_count, input total_chars,
                input letter_total, input ucase_total, input lcase_total,
                input blank_total, input digit_total, input other_total,
                input number_count, input number_sum, input last_record,
                output ready);
endinterface

>>> hw/rtl/tcs_hist_store.sv
// Letter histogram memory: synchronous read, write-to-read forwarding, per-entry valid bits.
module tcs_hist_store #(
  parameter int unsigned CountWidth = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 rd_en_i,
  input  logic [tcs_pkg::LetterIdxW-1:0]       rd_addr_i,
  input  logic                                 wr_en_i,
  input  logic [tcs_pkg::LetterIdxW-1:0]       wr_addr_i,
  input  logic [CountWidth-1:0]                wr_data_i,
  input  logic                                 clr_i,
  output logic [CountWidth-1:0]                rd_data_o
);

  logic [CountWidth-1:0]           mem_q [tcs_pkg::NumLetters];
  logic [tcs_pkg::NumLetters-1:0]  vld_q;
  logic [CountWidth-1:0]           rdata_q;
  logic [CountWidth-1:0]           fwd_q;
  logic                            rvld_q;
  logic                            hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
      fwd_q   <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
        // write landing on the same edge as the read: memory returns old data
        hit_q  <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  assign rd_data_o = hit_q ? fwd_q : (rvld_q ? rdata_q : '0);

endmodule

>>> hw/rtl/tcs_counters.sv
// Class counters, digit run tracking and histogram increment.
module tcs_counters #(
  parameter int unsigned CountWidth = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  upd_i,
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  input  logic                  clr_i,
  input  logic [CountWidth-1:0] hist_old_i,
  output logic [CountWidth-1:0] hist_new_o,
  output tcs_pkg::tcs_totals_t  totals_o
);

  logic [CountWidth-1:0]     cls_q [tcs_pkg::NumClasses];
  logic [CountWidth-1:0]     cls_d [tcs_pkg::NumClasses];
  logic [CountWidth-1:0]     run_cnt_q, run_cnt_d;
  logic [tcs_pkg::SumW-1:0]  run_val_q, run_val_d;
  logic [tcs_pkg::SumW-1:0]  run_sum_q, run_sum_d;
  logic                      in_run_q, in_run_d;

  logic                      low, up, blank, dig;
  logic [tcs_pkg::SumW-1:0]  base, new_val, close_val, sum_new;
  logic [34:0]               v10;
  logic [31:0]               sum_wide;
  logic                      closing;

  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] c);
    sat_inc = (&c) ? c : c + 1'b1;
  endfunction

  always_comb begin
    low   = tcs_pkg::is_lower(byte_i);
    up    = tcs_pkg::is_upper(byte_i);
    blank = tcs_pkg::is_blank(byte_i);
    dig   = tcs_pkg::is_digit(byte_i);

    // run value * 10 + digit, as shifts and adds
    base    = in_run_q ? run_val_q : '0;
    v10     = 35'({base, 3'b000}) + 35'({base, 1'b0}) + 35'(byte_i[3:0]);
    new_val = (v10 > 35'(tcs_pkg::SumMax)) ? tcs_pkg::SumMax : v10[tcs_pkg::SumW-1:0];

    // a run closes on a non-digit, or on a digit that ends the stream
    closing   = dig ? last_i : in_run_q;
    close_val = dig ? new_val : run_val_q;
    sum_wide  = 32'(run_sum_q) + 32'(close_val);
    sum_new   = sum_wide[31] ? tcs_pkg::SumMax : sum_wide[tcs_pkg::SumW-1:0];

    cls_d     = cls_q;
    run_cnt_d = run_cnt_q;
    run_val_d = run_val_q;
    run_sum_d = run_sum_q;
    in_run_d  = in_run_q;

    if (clr_i) begin
      for (int i = 0; i < int'(tcs_pkg::NumClasses); i++) begin
        cls_d[i] = '0;
      end
      run_cnt_d = '0;
      run_val_d = '0;
      run_sum_d = '0;
      in_run_d  = 1'b0;
    end else if (upd_i) begin
      cls_d[tcs_pkg::CcTotal] = sat_inc(cls_q[tcs_pkg::CcTotal]);
      if (low || up) begin
        cls_d[tcs_pkg::CcLetter] = sat_inc(cls_q[tcs_pkg::CcLetter]);
      end
      if (low) begin
        cls_d[tcs_pkg::CcLower] = sat_inc(cls_q[tcs_pkg::CcLower]);
      end
      if (up) begin
        cls_d[tcs_pkg::CcUpper] = sat_inc(cls_q[tcs_pkg::CcUpper]);
      end
      if (blank) begin
        cls_d[tcs_pkg::CcBlank] = sat_inc(cls_q[tcs_pkg::CcBlank]);
      end
      if (dig) begin
        cls_d[tcs_pkg::CcDigit] = sat_inc(cls_q[tcs_pkg::CcDigit]);
      end
      if (!(low || up || blank || dig)) begin
        cls_d[tcs_pkg::CcOther] = sat_inc(cls_q[tcs_pkg::CcOther]);
      end

      if (dig) begin
        if (!in_run_q) begin
          run_cnt_d = sat_inc(run_cnt_q);
        end
        run_val_d = closing ? '0 : new_val;
        in_run_d  = !closing;
      end else begin
        run_val_d = '0;
        in_run_d  = 1'b0;
      end
      if (closing) begin
        run_sum_d = sum_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(tcs_pkg::NumClasses); i++) begin
        cls_q[i] <= '0;
      end
      run_cnt_q <= '0;
      run_val_q <= '0;
      run_sum_q <= '0;
      in_run_q  <= 1'b0;
    end else begin
      cls_q     <= cls_d;
      run_cnt_q <= run_cnt_d;
      run_val_q <= run_val_d;
      run_sum_q <= run_sum_d;
      in_run_q  <= in_run_d;
    end
  end

  assign hist_new_o = sat_inc(hist_old_i);

  always_comb begin
    totals_o.total_chars  = tcs_pkg::FieldW'(cls_q[tcs_pkg::CcTotal]);
    totals_o.letter_total = tcs_pkg::FieldW'(cls_q[tcs_pkg::CcLetter]);
    totals_o.ucase_total  = tcs_pkg::FieldW'(cls_q[tcs_pkg::CcUpper]);
    totals_o.lcase_total  = tcs_pkg::FieldW'(cls_q[tcs_pkg::CcLower]);
    totals_o.blank_total  = tcs_pkg::FieldW'(cls_q[tcs_pkg::CcBlank]);
    totals_o.digit_total  = tcs_pkg::FieldW'(cls_q[tcs_pkg::CcDigit]);
    totals_o.other_total  = tcs_pkg::FieldW'(cls_q[tcs_pkg::CcOther]);
    totals_o.number_count = tcs_pkg::FieldW'(run_cnt_q);
    totals_o.number_sum   = run_sum_q;
  end

endmodule

>>> hw/rtl/tcs_report.sv
// Report sequencer: sweeps the histogram memory and feeds the output register.
module tcs_report #(
  parameter int unsigned CountWidth = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [CountWidth-1:0]  rd_data_i,
  input  tcs_pkg::tcs_totals_t   totals_i,
  output tcs_pkg::tcs_rd_req_t   rd_o,
  output tcs_pkg::tcs_rpt_ctrl_t ctrl_o,
  tcs_out_if.source              out_o
);

  localparam logic [tcs_pkg::LetterIdxW-1:0] IssEnd = tcs_pkg::LetterIdxW'(tcs_pkg::NumLetters);

  logic                            act_q;
  logic [tcs_pkg::LetterIdxW-1:0]  iss_q;
  logic                            pend_q;
  logic [tcs_pkg::LetterIdxW-1:0]  pidx_q;
  logic                            ovld_q;
  logic [tcs_pkg::LetterIdxW-1:0]  oidx_q;
  logic [tcs_pkg::FieldW-1:0]      ocnt_q;
  logic                            load, issue, done;

  // memory read data holds until the next read, so a stalled record just waits
  assign load  = pend_q && (!ovld_q || out_o.ready);
  assign issue = act_q && (iss_q != IssEnd) && (!pend_q || load);
  assign done  = ovld_q && out_o.ready && (oidx_q == tcs_pkg::LastLetter);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      iss_q  <= '0;
      pend_q <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      if (start_i) begin
        act_q <= 1'b1;
        iss_q <= '0;
      end else if (done) begin
        act_q <= 1'b0;
      end else if (issue) begin
        iss_q <= iss_q + 1'b1;
      end
      if (issue) begin
        pend_q <= 1'b1;
      end else if (load) begin
        pend_q <= 1'b0;
      end
      if (load) begin
        ovld_q <= 1'b1;
      end else if (out_o.ready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pidx_q <= iss_q;
    end
    if (load) begin
      oidx_q <= pidx_q;
      ocnt_q <= tcs_pkg::FieldW'(rd_data_i);
    end
  end

  assign rd_o.rd_en   = issue;
  assign rd_o.rd_addr = iss_q;
  assign ctrl_o.active = act_q;
  assign ctrl_o.done   = done;

  assign out_o.valid        = ovld_q;
  assign out_o.letter_index = oidx_q;
  assign out_o.letter_count = ocnt_q;
  assign out_o.total_chars  = totals_i.total_chars;
  assign out_o.letter_total = totals_i.letter_total;
  assign out_o.ucase_total  = totals_i.ucase_total;
  assign out_o.lcase_total  = totals_i.lcase_total;
  assign out_o.blank_total  = totals_i.blank_total;
  assign out_o.digit_total  = totals_i.digit_total;
  assign out_o.other_total  = totals_i.other_total;
  assign out_o.number_count = totals_i.number_count;
  assign out_o.number_sum   = totals_i.number_sum;
  assign out_o.last_record  = (oidx_q == tcs_pkg::LastLetter);

endmodule

>>> hw/rtl/text_character_statistics.sv
// Top level of the text character statistics block.
//
// Usage:
//   in_i  : one text byte per item (byte_req), with last marking the final byte
//           of a stream. Bytes are counted by class, lower case letters go into a
//           26-entry histogram, decimal digit runs are counted and summed.
//   out_o : produced only after a last byte: 26 records, letter a through z,
//           each with that letter's count and all stream totals; last_record
//           is set on the z record.
// Throughput and report order:
//   Ordinary bytes: one item per cycle. Accept issues the histogram read, the
//   next cycle increments and writes back (a same-entry write on the read's edge
//   is forwarded), so back-to-back bytes never stall.
//   Last byte: input is held off for the byte's update cycle plus the whole
//   report. The first record follows through the stage-1 register, the sweep
//   start, the first memory read and the output register; the sweep reads
//   ahead, one memory read per record, through the single histogram read port.
// Receiver stall: the record sits in the output register; the sweep pauses with
//   the next read result held in the memory's data register.
// Reset: all counts zero, histogram entries marked empty (they read as zero).
//   After the z record is taken every count and histogram entry clears at once.
module text_character_statistics #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcs_in_if.sink    in_i,
  tcs_out_if.source out_o
);

  // stage 1: byte whose histogram entry was read on accept
  logic        s1_vld_q;
  logic        s1_last_q;
  logic [7:0]  s1_byte_q;
  logic        accept;
  logic        start;

  logic [COUNT_WIDTH-1:0]           hist_old, hist_new;
  logic                             hs_rd_en, hs_wr_en;
  logic [tcs_pkg::LetterIdxW-1:0]   hs_rd_addr, hs_wr_addr;
  tcs_pkg::tcs_totals_t             totals;
  tcs_pkg::tcs_rd_req_t             rpt_rd;
  tcs_pkg::tcs_rpt_ctrl_t           rpt_ctrl;

  // input held while the last byte updates and while the report runs
  assign in_i.ready = !rpt_ctrl.active && !(s1_vld_q && s1_last_q);
  assign accept     = in_i.valid && in_i.ready;
  assign start      = s1_vld_q && s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
    end else begin
      s1_vld_q  <= accept;
      s1_last_q <= accept && in_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q <= in_i.byte_req;
    end
  end

  // one read port: byte path outside the report, sweep during it
  always_comb begin
    if (rpt_ctrl.active) begin
      hs_rd_en   = rpt_rd.rd_en;
      hs_rd_addr = rpt_rd.rd_addr;
    end else begin
      hs_rd_en   = accept && tcs_pkg::is_lower(in_i.byte_req);
      hs_rd_addr = tcs_pkg::LetterIdxW'(in_i.byte_req - tcs_pkg::ChLowA);
    end
  end

  assign hs_wr_en   = s1_vld_q && tcs_pkg::is_lower(s1_byte_q);
  assign hs_wr_addr = tcs_pkg::LetterIdxW'(s1_byte_q - tcs_pkg::ChLowA);

  tcs_hist_store #(
    .CountWidth (COUNT_WIDTH)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (hs_rd_en),
    .rd_addr_i (hs_rd_addr),
    .wr_en_i   (hs_wr_en),
    .wr_addr_i (hs_wr_addr),
    .wr_data_i (hist_new),
    .clr_i     (rpt_ctrl.done),
    .rd_data_o (hist_old)
  );

  tcs_counters #(
    .CountWidth (COUNT_WIDTH)
  ) u_cnt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (s1_vld_q),
    .byte_i     (s1_byte_q),
    .last_i     (s1_last_q),
    .clr_i      (rpt_ctrl.done),
    .hist_old_i (hist_old),
    .hist_new_o (hist_new),
    .totals_o   (totals)
  );

  tcs_report #(
    .CountWidth (COUNT_WIDTH)
  ) u_rpt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .rd_data_i (hist_old),
    .totals_i  (totals),
    .rd_o      (rpt_rd),
    .ctrl_o    (rpt_ctrl),
    .out_o     (out_o)
  );

endmodule

>>> hw/rtl/tcs_checker.sv
// Port-level assertions for the character statistics block, bound to the top level.
module tcs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_last_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [4:0] out_index_i,
  input logic       out_last_i
);

  // a stalled record stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_index_i))
    else $error("record dropped while stalled");

  // input is closed whenever a report record is offered
  a_no_in_during_rpt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input open during report");

  // the last byte closes the input at once
  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("input open after last byte");

  // nothing follows the z record
  a_rpt_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_last_i |=> !out_valid_i)
    else $error("record after end of report");

  // last_record marks exactly the z record
  a_last_is_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_last_i == (out_index_i == 5'd25)))
    else $error("last_record on wrong letter");

endmodule

bind text_character_statistics tcs_checker u_tcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_index_i (out_o.letter_index),
  .out_last_i  (out_o.last_record)
);

>>> tb/text_character_statistics_test.sv
// Self-checking testbench for the text character statistics block.
`timescale 1ns / 1ps

module text_character_statistics_test;

  // no item moving in either direction for this many cycles means a hang
  localparam int HangLimit    = 2000;
  // cycles allowed after the last record before the verdict
  localparam int DrainWait    = 10;
  localparam int PhaseItems   = 65;
  localparam int PrintCap     = 20;
  // a block that keeps producing wrong records is stopped here
  localparam int MismatchStop = 500;

  typedef logic [7:0] text_t[$];

  // one report record: letter, its count, the stream totals, end marker
  typedef struct packed {
    logic [tcs_pkg::LetterIdxW-1:0] idx;
    logic [tcs_pkg::FieldW-1:0]     count;
    tcs_pkg::tcs_totals_t           totals;
    logic                           last_rec;
  } letter_report_t;

  // Tracks the block's counts item by item and holds the report records that
  // the next last byte must produce, oldest first.
  class letter_report_board;
    logic [tcs_pkg::FieldW-1:0] hist[tcs_pkg::NumLetters];
    tcs_pkg::tcs_totals_t       tally;
    logic [tcs_pkg::SumW-1:0]   run_val;
    bit                         in_run;
    letter_report_t             due_reports[$];
    int                         mismatches;
    int                         checked;
    int                         streams;

    function new();
      clear();
    endfunction

    function void clear();
      foreach (hist[i]) hist[i] = '0;
      tally   = '0;
      run_val = '0;
      in_run  = 1'b0;
    endfunction

    function logic [tcs_pkg::FieldW-1:0] bump(logic [tcs_pkg::FieldW-1:0] c);
      return (&c) ? c : c + 1'b1;
    endfunction

    // fold an open digit run into the sum, clamped at the sum maximum
    function void close_run();
      logic [tcs_pkg::SumW+1:0] s;
      if (!in_run) return;
      s = {2'b00, tally.number_sum} + {2'b00, run_val};
      tally.number_sum = (s > tcs_pkg::SumMax) ? tcs_pkg::SumMax : s[tcs_pkg::SumW-1:0];
      run_val = '0;
      in_run  = 1'b0;
    endfunction

    function void take_byte(logic [7:0] b, logic lst);
      logic [tcs_pkg::SumW+4:0] v;
      letter_report_t           r;
      bit                       digit;
      digit = (b >= tcs_pkg::ChZero) && (b <= tcs_pkg::ChNine);
      if (b >= tcs_pkg::ChLowA && b <= tcs_pkg::ChLowZ) begin
        tally.letter_total        = bump(tally.letter_total);
        tally.lcase_total         = bump(tally.lcase_total);
        hist[b - tcs_pkg::ChLowA] = bump(hist[b - tcs_pkg::ChLowA]);
      end else if (b >= tcs_pkg::ChUpA && b <= tcs_pkg::ChUpZ) begin
        // upper case counts as a letter but stays out of the histogram
        tally.letter_total = bump(tally.letter_total);
        tally.ucase_total  = bump(tally.ucase_total);
      end else if (b == tcs_pkg::ChSpace || b == tcs_pkg::ChTab) begin
        tally.blank_total = bump(tally.blank_total);
      end else if (digit) begin
        tally.digit_total = bump(tally.digit_total);
      end else begin
        tally.other_total = bump(tally.other_total);
      end
      tally.total_chars = bump(tally.total_chars);

      if (digit) begin
        if (!in_run) begin
          in_run  = 1'b1;
          run_val = '0;
          tally.number_count = bump(tally.number_count);
        end
        v = {5'd0, run_val} * 10 + {(tcs_pkg::SumW - 3)'(0), b - tcs_pkg::ChZero};
        run_val = (v > tcs_pkg::SumMax) ? tcs_pkg::SumMax : v[tcs_pkg::SumW-1:0];
      end else begin
        close_run();
      end

      if (!lst) return;
      // a run still open at the last byte is counted before the report
      close_run();
      streams++;
      for (int k = 0; k < tcs_pkg::NumLetters; k++) begin
        r.idx      = tcs_pkg::LetterIdxW'(k);
        r.count    = hist[k];
        r.totals   = tally;
        r.last_rec = (k == tcs_pkg::NumLetters - 1);
        due_reports.push_back(r);
      end
      clear();
    endfunction

    task report(string msg);
      if (mismatches < PrintCap) $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task cmp(string name, int letter, logic [tcs_pkg::FieldW-1:0] got,
             logic [tcs_pkg::FieldW-1:0] want);
      if (got !== want)
        report($sformatf("record %0d %s got %0h want %0h", letter, name, got, want));
    endtask

    task check_report(letter_report_t got);
      letter_report_t want;
      if (due_reports.size() == 0) begin
        report($sformatf("record for letter %0d with none expected", got.idx));
        return;
      end
      want = due_reports.pop_front();
      checked++;
      cmp("letter_index", want.idx, got.idx, want.idx);
      cmp("letter_count", want.idx, got.count, want.count);
      cmp("total_chars", want.idx, got.totals.total_chars, want.totals.total_chars);
      cmp("letter_total", want.idx, got.totals.letter_total, want.totals.letter_total);
      cmp("ucase_total", want.idx, got.totals.ucase_total, want.totals.ucase_total);
      cmp("lcase_total", want.idx, got.totals.lcase_total, want.totals.lcase_total);
      cmp("blank_total", want.idx, got.totals.blank_total, want.totals.blank_total);
      cmp("digit_total", want.idx, got.totals.digit_total, want.totals.digit_total);
      cmp("other_total", want.idx, got.totals.other_total, want.totals.other_total);
      cmp("number_count", want.idx, got.totals.number_count, want.totals.number_count);
      cmp("number_sum", want.idx, got.totals.number_sum, want.totals.number_sum);
      cmp("last_record", want.idx, got.last_rec, want.last_rec);
    endtask
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic rx_ready = 1'b0;

  // idle odds in percent, changed per phase
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int items_sent    = 0;
  int quiet_cycles  = 0;

  letter_report_board board = new();
  letter_report_t     seen;

  tcs_in_if  in_if ();
  tcs_out_if out_if ();

  assign out_if.ready = rx_ready;

  text_character_statistics uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: stalls at random, held low during reset
  always @(negedge clk) begin
    rx_ready <= rst_n && ($urandom_range(99) >= snk_stall_pct);
  end

  // record monitor: sampled at the rising edge where the handshake completes
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      seen.idx             = out_if.letter_index;
      seen.count           = out_if.letter_count;
      seen.totals.total_chars  = out_if.total_chars;
      seen.totals.letter_total = out_if.letter_total;
      seen.totals.ucase_total  = out_if.ucase_total;
      seen.totals.lcase_total  = out_if.lcase_total;
      seen.totals.blank_total  = out_if.blank_total;
      seen.totals.digit_total  = out_if.digit_total;
      seen.totals.other_total  = out_if.other_total;
      seen.totals.number_count = out_if.number_count;
      seen.totals.number_sum   = out_if.number_sum;
      seen.last_rec        = out_if.last_record;
      board.check_report(seen);
      if (board.mismatches >= MismatchStop) begin
        $display("too many mismatches, stopping");
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // watchdog: counts cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= HangLimit) begin
      $display("no progress for %0d cycles", HangLimit);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drive one byte, starting at a falling edge; returns at the falling edge
  // after it was accepted. Valid only drops while the sender idles.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.byte_req <= b;
    in_if.last     <= lst;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    board.take_byte(b, lst);
    items_sent++;
    @(negedge clk);
  endtask

  // one stream; the final byte carries last and triggers the report
  task automatic send_text(input text_t text);
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  // Random stream. Plain streams mix every class with short digit runs;
  // numeric streams are long runs split by blanks so the run value and the
  // sum reach their clamp.
  task automatic send_random_stream(input bit numeric);
    text_t text;
    int    len;
    int    pick;
    int    run;
    len = numeric ? $urandom_range(20, 40) : $urandom_range(1, 24);
    while (text.size() < len) begin
      pick = $urandom_range(99);
      if (numeric) begin
        if (pick < 65) begin
          run = $urandom_range(8, 12);
          repeat (run) text.push_back(8'(tcs_pkg::ChZero + $urandom_range(9)));
        end else begin
          text.push_back(($urandom_range(1)) ? tcs_pkg::ChSpace : tcs_pkg::ChTab);
        end
      end else if (pick < 30) begin
        text.push_back(8'(tcs_pkg::ChLowA + $urandom_range(25)));
      end else if (pick < 40) begin
        text.push_back(8'(tcs_pkg::ChUpA + $urandom_range(25)));
      end else if (pick < 50) begin
        text.push_back(($urandom_range(1)) ? tcs_pkg::ChSpace : tcs_pkg::ChTab);
      end else if (pick < 70) begin
        run = $urandom_range(1, 4);
        repeat (run) text.push_back(8'(tcs_pkg::ChZero + $urandom_range(9)));
      end else begin
        text.push_back(8'($urandom_range(255)));
      end
    end
    send_text(text);
  endtask

  initial begin
    text_t probe;
    int    phase_end;

    // class boundaries on both sides, blanks, control bytes, high bytes,
    // and a digit run still open on the last byte
    probe = '{8'h00, tcs_pkg::ChLowA, tcs_pkg::ChLowZ, tcs_pkg::ChUpA, tcs_pkg::ChUpZ,
              8'h60, 8'h7B, 8'h40, 8'h5B, tcs_pkg::ChSpace, tcs_pkg::ChTab, 8'h08,
              8'h0A, 8'h2F, 8'h3A, tcs_pkg::ChZero, tcs_pkg::ChNine, 8'h7F, 8'h80,
              8'hFF, 8'h34, 8'h32};

    in_if.valid    = 1'b0;
    in_if.byte_req = '0;
    in_if.last     = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_text(probe);
    send_text('{8'h71});   // one-letter stream
    send_text('{8'h37});   // one-digit stream, run open at last

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 49; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 49; end
        default: begin src_idle_pct = 33; snk_stall_pct = 33; end
      endcase
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) send_random_stream($urandom_range(3) == 0);
    end
    in_if.valid <= 1'b0;

    // the watchdog bounds this wait
    while (board.due_reports.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("sent %0d bytes in %0d streams under four idle mixes", items_sent,
             board.streams);
    $display("checked %0d letter records, %0d mismatches", board.checked,
             board.mismatches);
    if (board.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> text_character_statistics.f
hw/rtl/tcs_pkg.sv
hw/rtl/tcs_if.sv
hw/rtl/tcs_hist_store.sv
hw/rtl/tcs_counters.sv
hw/rtl/tcs_report.sv
hw/rtl/text_character_statistics.sv
hw/rtl/tcs_checker.sv
tb/text_character_statistics_test.sv
